@@ design/assert_macros.svh @@
// Assertion helpers included by prime_position_reporter.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: expression does not hold");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: consequent missing in next cycle");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/ppr_pkg.sv @@
package ppr_pkg;

  localparam int VAL_W     = 31;   // magnitude bits of a non-negative value
  localparam int IN_W      = 32;
  localparam int DIV_W     = 16;   // trial divisors never exceed 46341
  localparam int SQ_W      = 32;   // square of the trial divisor
  localparam int STEP_W    = 5;    // counts the quotient bits of one division
  localparam int POS_W     = 7;
  localparam int MAX_ITEMS = 128;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } rem_rsp_t;

endpackage

@@ design/ppr_if.sv @@
interface ppr_in_if import ppr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value;
  logic                   last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface ppr_out_if import ppr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] prime_value;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output prime_value, output position,
                  input ready);
  modport sink   (input valid, input found, input prime_value, input position,
                  output ready);
endinterface

@@ design/ppr_rem.sv @@
module ppr_rem import ppr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  rem_next;
  logic [DIV_W-1:0]  divisor;
  logic [VAL_W-1:0]  shreg;
  logic [DIV_W:0]    trial;

  // Restoring remainder: one dividend bit enters per cycle, most significant first.
  always_comb begin
    trial = {rem, shreg[VAL_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DIV_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = DIV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        divisor <= req.divisor;
        shreg   <= req.dividend;
      end else if (busy) begin
        rem   <= rem_next;
        shreg <= {shreg[VAL_W-2:0], 1'b0};
        cnt   <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.rem_zero = (rem == '0);

endmodule

@@ design/prime_position_reporter.sv @@
// Tests each incoming value for primality by trial division and reports every prime
// with its zero-based position in the array; an array whose last item arrives with no
// prime seen gives a single report with found low and zero fields. One item is worked
// on at a time and the input is not ready meanwhile. Negative values, zero and one
// finish without any division; otherwise trial divisors are tried in turn from 2 up to
// the integer square root, stopping at the first one that divides the value. Each
// division is done by the remainder unit, which produces one quotient bit per cycle. A
// finished report sits in an output register, so the next item can be accepted while
// it waits to be taken. Positions wrap to zero after 127 within one long array.
`include "assert_macros.svh"

module prime_position_reporter import ppr_pkg::*; (
  input logic       clk,
  input logic       rst,
  ppr_in_if.sink    data,
  ppr_out_if.source result
);

  state_t           state;
  state_t           state_next;
  logic [VAL_W-1:0] n;
  logic             last_r;
  logic             prime_r;
  logic [DIV_W-1:0] d;
  logic [SQ_W-1:0]  sq;
  logic [IDX_W-1:0] idx;
  logic             seen;

  logic             out_valid;
  logic             out_found;
  logic [VAL_W-1:0] out_val;
  logic [POS_W-1:0] out_pos;

  logic             accept;
  logic             below_two;
  logic             want_emit;
  logic             load_out;
  logic             finish;
  rem_req_t         req;
  rem_rsp_t         rsp;

  ppr_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign accept    = data.valid && data.ready;
  assign below_two = data.value[IN_W-1] || (data.value[VAL_W-1:1] == '0);
  assign want_emit = prime_r || (last_r && !seen);

  always_comb begin
    state_next   = state;
    req.start    = 1'b0;
    req.dividend = n;
    req.divisor  = d;
    load_out     = 1'b0;
    finish       = 1'b0;
    data.ready   = 1'b0;
    case (state)
      S_IDLE: begin
        data.ready = 1'b1;
        if (data.valid) begin
          state_next = below_two ? S_DONE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (sq > SQ_W'(n)) begin
          state_next = S_DONE;
        end else begin
          req.start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (rsp.done) begin
          state_next = rsp.rem_zero ? S_DONE : S_CHECK;
        end
      end
      S_DONE: begin
        // Hold here only when a report is due and the output slot is full and not being taken.
        if (!want_emit || !out_valid || result.ready) begin
          load_out   = want_emit;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      seen    <= 1'b0;
      prime_r <= 1'b0;
    end else begin
      if (accept) begin
        n       <= data.value[VAL_W-1:0];
        last_r  <= data.last_item;
        prime_r <= 1'b0;
        d       <= DIV_W'(2);
        sq      <= SQ_W'(4);
      end
      if (state == S_CHECK && sq > SQ_W'(n)) begin
        prime_r <= 1'b1;
      end
      if (state == S_DIV && rsp.done && !rsp.rem_zero) begin
        // (d+1)^2 = d^2 + 2d + 1
        d  <= d + DIV_W'(1);
        sq <= sq + SQ_W'({d, 1'b1});
      end
      if (finish) begin
        if (last_r) begin
          idx  <= '0;
          seen <= 1'b0;
        end else begin
          seen <= seen || prime_r;
          if (idx == IDX_W'(MAX_ITEMS - 1)) begin
            idx <= '0;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_found <= prime_r;
        out_val   <= prime_r ? n : '0;
        out_pos   <= prime_r ? POS_W'(idx) : '0;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.found       = out_found;
  assign result.prime_value = out_val;
  assign result.position    = out_pos;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !data.ready)
  `ASSERT_ALWAYS(a_div_only_in_div, clk, rst, !rsp.busy || state == S_DIV)
  `ASSERT_ALWAYS(a_prime_at_least_two, clk, rst,
                 !(result.valid && result.found) || result.prime_value >= VAL_W'(2))
  `ASSERT_ALWAYS(a_none_report_zero, clk, rst,
                 !(result.valid && !result.found) ||
                 (result.prime_value == '0 && result.position == '0))

endmodule
